[hdl/can_frame_capture_ring_defines.svh]
// assertion macros for the can frame capture ring
// users supply i_clk and i_rst_n in the module that expands them
`ifndef CAN_FRAME_CAPTURE_RING_DEFINES_SVH
`define CAN_FRAME_CAPTURE_RING_DEFINES_SVH

// same-cycle implication
`define CFCR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CFCR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/cfcr_pkg.sv]
// shared types, constants and helpers for the can frame capture ring
// no dependencies
package cfcr_pkg;

    localparam int RING_DEPTH   = 4096;
    localparam int FILTER_SLOTS = 4;
    localparam int ID_REGS      = 4;
    localparam int ID_USED      = (FILTER_SLOTS < ID_REGS) ? FILTER_SLOTS : ID_REGS;
    localparam int PTR_W        = $clog2(RING_DEPTH);
    localparam int FILL_W       = 12;
    localparam int CNT_W        = 32;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 32;
    localparam int Q_DEPTH      = 2;
    localparam int Q_PTR_W      = 1;
    localparam logic [3:0] MAX_DLC = 4'd8;

    typedef logic [PTR_W-1:0]  t_ptr;
    typedef logic [FILL_W-1:0] t_fill;
    typedef logic [CNT_W-1:0]  t_cnt;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_STREAM_EN = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUS_EN    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BUS_SEL   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ID_COUNT  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ID_A      = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ID_B      = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ID_C      = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ID_D      = 4'd7;

    // operation codes of an input item
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_POP    = 1'b1;

    // classification handed from front to back
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_IGNORE = 2'd0;
    localparam t_kind KIND_FILTER = 2'd1;
    localparam t_kind KIND_STORE  = 2'd2;
    localparam t_kind KIND_POP    = 2'd3;

    typedef struct packed {
        logic        op;
        logic [31:0] stamp_ms;
        logic        bus;
        logic [28:0] can_id;
        logic [3:0]  dlc;
        logic [63:0] payload;
    } t_in_item;

    typedef struct packed {
        logic        entry_valid;
        logic [31:0] out_stamp_ms;
        logic        out_bus;
        logic [28:0] out_can_id;
        logic [3:0]  out_dlc;
        logic [63:0] out_payload;
        logic        was_filtered;
        logic        overwrote_oldest;
        t_fill       fill_level;
        t_cnt        sent_total;
        t_cnt        dropped_total;
        t_cnt        filtered_total;
    } t_out_item;

    // one ring entry as stored
    typedef struct packed {
        logic [31:0] stamp_ms;
        logic        bus;
        logic [28:0] can_id;
        logic [3:0]  dlc;
        logic [63:0] payload;
    } t_entry;

    typedef struct packed {
        t_kind  kind;
        t_entry entry;
    } t_qitem;

    // session start or end seen on the stream enable register
    typedef struct packed {
        logic clear_ring;
        logic clear_counts;
    } t_sess_evt;

    function automatic t_ptr ptr_adv(input t_ptr p);
        t_ptr r;
        if (p == t_ptr'(RING_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + t_ptr'(1);
        end
        return r;
    endfunction

endpackage

[hdl/cfcr_front.sv]
// front end: configuration registers, acceptance filter, item classification
// depends on cfcr_pkg
module cfcr_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  cfcr_pkg::t_in_item              i_in,
    input  logic                            i_q_full,
    input  logic                            i_cfg_valid,
    input  logic [cfcr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cfcr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_cfg_ready,
    output logic                            o_push,
    output cfcr_pkg::t_qitem                o_item,
    output cfcr_pkg::t_sess_evt             o_evt
);

    logic        r_enable;
    logic        r_bus_en;
    logic        r_bus_sel;
    logic [2:0]  r_id_count;
    logic [28:0] r_ids [cfcr_pkg::ID_REGS];

    logic        cfg_we;
    logic [2:0]  n_use;
    logic        id_ok;
    logic [3:0]  dlc_sat;
    logic [63:0] data_masked;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;
    assign o_push      = start && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_bus_en   <= 1'b0;
            r_bus_sel  <= 1'b0;
            r_id_count <= 3'd0;
            for (int i = 0; i < cfcr_pkg::ID_REGS; i++) begin
                r_ids[i] <= '0;
            end
        end else if (cfg_we) begin
            case (i_cfg_index)
                cfcr_pkg::REG_STREAM_EN: r_enable   <= i_cfg_data[0];
                cfcr_pkg::REG_BUS_EN:    r_bus_en   <= i_cfg_data[0];
                cfcr_pkg::REG_BUS_SEL:   r_bus_sel  <= i_cfg_data[0];
                cfcr_pkg::REG_ID_COUNT:  r_id_count <= i_cfg_data[2:0];
                cfcr_pkg::REG_ID_A:      r_ids[0]   <= i_cfg_data[28:0];
                cfcr_pkg::REG_ID_B:      r_ids[1]   <= i_cfg_data[28:0];
                cfcr_pkg::REG_ID_C:      r_ids[2]   <= i_cfg_data[28:0];
                cfcr_pkg::REG_ID_D:      r_ids[3]   <= i_cfg_data[28:0];
                default: ;
            endcase
        end
    end

    // a change of the stream enable empties the ring, a rising one also clears counters
    always_comb begin
        o_evt = '0;
        if (cfg_we && i_cfg_index == cfcr_pkg::REG_STREAM_EN &&
            i_cfg_data[0] != r_enable) begin
            o_evt.clear_ring   = 1'b1;
            o_evt.clear_counts = i_cfg_data[0];
        end
    end

    always_comb begin
        n_use = (r_id_count > 3'(cfcr_pkg::ID_USED)) ? 3'(cfcr_pkg::ID_USED) : r_id_count;
        id_ok = (n_use == 3'd0);
        for (int i = 0; i < cfcr_pkg::ID_REGS; i++) begin
            if (3'(i) < n_use && r_ids[i] == i_in.can_id) begin
                id_ok = 1'b1;
            end
        end
    end

    always_comb begin
        dlc_sat = (i_in.dlc > cfcr_pkg::MAX_DLC) ? cfcr_pkg::MAX_DLC : i_in.dlc;
        for (int b = 0; b < 8; b++) begin
            data_masked[b*8 +: 8] = (4'(b) < dlc_sat) ? i_in.payload[b*8 +: 8] : 8'h00;
        end
    end

    always_comb begin
        o_item.entry.stamp_ms = i_in.stamp_ms;
        o_item.entry.bus      = i_in.bus;
        o_item.entry.can_id   = i_in.can_id;
        o_item.entry.dlc      = dlc_sat;
        o_item.entry.payload  = data_masked;
        if (i_in.op == cfcr_pkg::OP_POP) begin
            o_item.kind = cfcr_pkg::KIND_POP;
        end else if (!r_enable) begin
            o_item.kind = cfcr_pkg::KIND_IGNORE;
        end else if ((r_bus_en && i_in.bus != r_bus_sel) || !id_ok) begin
            o_item.kind = cfcr_pkg::KIND_FILTER;
        end else begin
            o_item.kind = cfcr_pkg::KIND_STORE;
        end
    end

endmodule

[hdl/cfcr_queue.sv]
// two-entry queue of classified items between front and back
// depends on cfcr_pkg
module cfcr_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cfcr_pkg::t_qitem i_item,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output cfcr_pkg::t_qitem o_head
);

    localparam int CNT_QW = cfcr_pkg::Q_PTR_W + 1;

    cfcr_pkg::t_qitem             r_slot [cfcr_pkg::Q_DEPTH];
    logic [cfcr_pkg::Q_PTR_W-1:0] r_wp;
    logic [cfcr_pkg::Q_PTR_W-1:0] r_rp;
    logic [CNT_QW-1:0]            r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == CNT_QW'(cfcr_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_slot[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CNT_QW'(1);
                2'b01:   r_cnt <= r_cnt - CNT_QW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_item;
        end
    end

endmodule

[hdl/cfcr_back.sv]
// back end: ring memory, pointers, counters and result register
// depends on cfcr_pkg and the assertion macro header
`include "can_frame_capture_ring_defines.svh"

module cfcr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  cfcr_pkg::t_qitem    i_head,
    input  cfcr_pkg::t_sess_evt i_evt,
    output logic                o_pull,
    output logic                o_done,
    output cfcr_pkg::t_out_item o_out
);

    localparam int LVL_W = cfcr_pkg::PTR_W + 1;

    cfcr_pkg::t_entry mem [cfcr_pkg::RING_DEPTH];

    cfcr_pkg::t_ptr   r_wr,       n_wr;
    cfcr_pkg::t_ptr   r_rd,       n_rd;
    cfcr_pkg::t_cnt   r_sent,     n_sent;
    cfcr_pkg::t_cnt   r_dropped,  n_dropped;
    cfcr_pkg::t_cnt   r_filtered, n_filtered;
    logic             r_emit,     n_emit;
    logic             r_valid,    n_valid;
    logic             r_filt,     n_filt;
    logic             r_over,     n_over;
    cfcr_pkg::t_entry r_rdq;

    logic             no_entries;
    logic             at_capacity;
    logic             mem_we;
    logic             mem_re;
    logic [LVL_W-1:0] level;

    assign no_entries  = (r_wr == r_rd);
    assign at_capacity = (cfcr_pkg::ptr_adv(r_wr) == r_rd);
    // the user must make a session change only while idle; the block does not enforce it, and it still wins over a pull
    assign o_pull      = !i_empty && !i_evt.clear_ring;

    always_comb begin
        n_wr       = r_wr;
        n_rd       = r_rd;
        n_sent     = r_sent;
        n_dropped  = r_dropped;
        n_filtered = r_filtered;
        n_emit     = o_pull;
        n_valid    = 1'b0;
        n_filt     = 1'b0;
        n_over     = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        if (i_evt.clear_ring) begin
            n_wr = '0;
            n_rd = '0;
            if (i_evt.clear_counts) begin
                n_sent     = '0;
                n_dropped  = '0;
                n_filtered = '0;
            end
        end else if (o_pull) begin
            case (i_head.kind)
                cfcr_pkg::KIND_FILTER: begin
                    n_filtered = r_filtered + cfcr_pkg::t_cnt'(1);
                    n_filt     = 1'b1;
                end
                cfcr_pkg::KIND_STORE: begin
                    mem_we = 1'b1;
                    n_wr   = cfcr_pkg::ptr_adv(r_wr);
                    if (at_capacity) begin
                        n_dropped = r_dropped + cfcr_pkg::t_cnt'(1);
                        n_rd      = cfcr_pkg::ptr_adv(r_rd);
                        n_over    = 1'b1;
                    end
                end
                cfcr_pkg::KIND_POP: begin
                    if (!no_entries) begin
                        mem_re  = 1'b1;
                        n_rd    = cfcr_pkg::ptr_adv(r_rd);
                        n_sent  = r_sent + cfcr_pkg::t_cnt'(1);
                        n_valid = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr       <= '0;
            r_rd       <= '0;
            r_sent     <= '0;
            r_dropped  <= '0;
            r_filtered <= '0;
            r_emit     <= 1'b0;
            r_valid    <= 1'b0;
            r_filt     <= 1'b0;
            r_over     <= 1'b0;
        end else begin
            r_wr       <= n_wr;
            r_rd       <= n_rd;
            r_sent     <= n_sent;
            r_dropped  <= n_dropped;
            r_filtered <= n_filtered;
            r_emit     <= n_emit;
            r_valid    <= n_valid;
            r_filt     <= n_filt;
            r_over     <= n_over;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_wr] <= i_head.entry;
        end
        if (mem_re) begin
            r_rdq <= mem[r_rd];
        end
    end

    // pointer state is already the post-item state while the result shows
    always_comb begin
        if (r_wr >= r_rd) begin
            level = {1'b0, r_wr} - {1'b0, r_rd};
        end else begin
            level = {1'b0, r_wr} + LVL_W'(cfcr_pkg::RING_DEPTH) - {1'b0, r_rd};
        end
    end

    always_comb begin
        o_done                 = r_emit;
        o_out.entry_valid      = r_valid;
        o_out.out_stamp_ms     = r_valid ? r_rdq.stamp_ms : '0;
        o_out.out_bus          = r_valid ? r_rdq.bus : 1'b0;
        o_out.out_can_id       = r_valid ? r_rdq.can_id : '0;
        o_out.out_dlc          = r_valid ? r_rdq.dlc : '0;
        o_out.out_payload      = r_valid ? r_rdq.payload : '0;
        o_out.was_filtered     = r_filt;
        o_out.overwrote_oldest = r_over;
        o_out.fill_level       = cfcr_pkg::FILL_W'(level);
        o_out.sent_total       = r_sent;
        o_out.dropped_total    = r_dropped;
        o_out.filtered_total   = r_filtered;
    end

    `CFCR_ASSERT_NXT(a_pull_gives_result, o_pull, r_emit, "pulled item gave no result")
    `CFCR_ASSERT_IMP(a_overwrite_at_full, r_emit && r_over, level == LVL_W'(cfcr_pkg::RING_DEPTH - 1), "overwrite left ring not full")
    `CFCR_ASSERT_NXT(a_pop_counts_sent, o_pull && i_head.kind == cfcr_pkg::KIND_POP && !no_entries, r_valid && r_sent == $past(r_sent) + 1'b1, "pop of held entry not counted")
    `CFCR_ASSERT_IMP(a_ptr_in_range, 1'b1, {1'b0, r_wr} < LVL_W'(cfcr_pkg::RING_DEPTH) && {1'b0, r_rd} < LVL_W'(cfcr_pkg::RING_DEPTH), "ring pointer out of range")

endmodule

[hdl/can_frame_capture_ring.sv]
// top level of the can frame capture ring: front, queue and back joined
// depends on cfcr_pkg, cfcr_front, cfcr_queue, cfcr_back
//
//  channel   handshake                      payload
//  input     start / busy                   i_in  (t_in_item)
//  result    o_done strobe, one cycle       o_out (t_out_item)
//  config    i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// one item per cycle sustained unless a session change holds off the pull; a result
// shows after its item has passed the queue and then the ring memory read register
// busy rises only when the two-entry queue is full; config is always ready
// reset clears pointers, counters and config; ring contents are not cleared
// the result strobe cannot be stalled, so the back end never waits
module can_frame_capture_ring (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  cfcr_pkg::t_in_item              i_in,
    output logic                            o_done,
    output cfcr_pkg::t_out_item             o_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cfcr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cfcr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic                q_full;
    logic                q_empty;
    logic                push;
    logic                pull;
    cfcr_pkg::t_qitem    front_item;
    cfcr_pkg::t_qitem    head_item;
    cfcr_pkg::t_sess_evt sess_evt;

    assign busy = q_full;

    cfcr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_push      (push),
        .o_item      (front_item),
        .o_evt       (sess_evt)
    );

    cfcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pull),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_item)
    );

    cfcr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (head_item),
        .i_evt   (sess_evt),
        .o_pull  (pull),
        .o_done  (o_done),
        .o_out   (o_out)
    );

endmodule
